[rtl/dpb_pkg.sv]
// ----------------------------------------------------------------------------
// Depth pixel back-projection package
// Shared payload types, register indexes, reset values and stage controls.
// ----------------------------------------------------------------------------
package dpb_pkg;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 24;
   localparam int OFFSET_WIDTH    = 18;
   localparam int PROJ_WIDTH      = 46;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INV_DEPTH_SCALE = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CENTER_COL      = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CENTER_ROW      = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INV_FOCAL_X     = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INV_FOCAL_Y     = 3'd4;

   localparam logic [23:0] INV_DEPTH_SCALE_RESET = 24'd16777;
   localparam logic [15:0] CENTER_COL_RESET      = 16'd5120;
   localparam logic [15:0] CENTER_ROW_RESET      = 16'd3840;
   localparam logic [23:0] INV_FOCAL_X_RESET     = 24'd31957;
   localparam logic [23:0] INV_FOCAL_Y_RESET     = 24'd31957;

   typedef struct packed {
      logic [11:0] col;
      logic [11:0] row;
      logic [15:0] depth;
      logic [7:0]  blue;
      logic [7:0]  green;
      logic [7:0]  red;
   } req_type;

   typedef struct packed {
      logic [31:0]        forward;
      logic signed [31:0] lateral;
      logic signed [31:0] vertical;
      logic [7:0]         out_blue;
      logic [7:0]         out_green;
      logic [7:0]         out_red;
   } rsp_type;

   typedef struct packed {
      logic s2;
      logic s3;
      logic s4;
   } stage_en_type;

endpackage

[rtl/dpb_axis.sv]
// ----------------------------------------------------------------------------
// Depth pixel back-projection, one image axis
// Scales a signed pixel offset by the forward distance and a reciprocal focal
// length over three register stages, with saturation to 32 bits.
// ----------------------------------------------------------------------------
module dpb_axis (
   input  logic                                      clock,
   input  dpb_pkg::stage_en_type                     stage_en,
   input  logic signed [dpb_pkg::OFFSET_WIDTH-1:0]   offset,
   input  logic [31:0]                               forward,
   input  logic [23:0]                               inv_focal,
   output logic signed [31:0]                        result
);

   localparam int PW = dpb_pkg::PROJ_WIDTH;

   logic signed [50:0]   scaled_prod;
   logic signed [PW-1:0] proj_in;
   logic signed [PW-1:0] proj_ff;

   logic signed [21:0]   proj_hi;
   logic signed [46:0]   hi_prod_in;
   logic signed [46:0]   hi_prod_ff;
   logic [47:0]          lo_prod;
   logic [23:0]          lo_part_in;
   logic [23:0]          lo_part_ff;

   logic signed [47:0]   sum;
   logic signed [31:0]   result_in;
   logic signed [31:0]   result_ff;

   assign scaled_prod = 51'(offset) * 51'($signed({1'b0, forward}));
   assign proj_in     = scaled_prod[PW+3:4];

   assign proj_hi    = proj_ff[PW-1:24];
   assign hi_prod_in = 47'(proj_hi) * 47'($signed({1'b0, inv_focal}));
   assign lo_prod    = {24'd0, proj_ff[23:0]} * {24'd0, inv_focal};
   assign lo_part_in = lo_prod[47:24];

   assign sum = 48'(hi_prod_ff) + $signed({24'd0, lo_part_ff});

   always_comb begin
      if (sum > 48'sd2147483647) begin
         result_in = 32'sh7FFF_FFFF;
      end else if (sum < -48'sd2147483648) begin
         result_in = 32'sh8000_0000;
      end else begin
         result_in = sum[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.s2) begin
         proj_ff <= proj_in;
      end
      if (stage_en.s3) begin
         hi_prod_ff <= hi_prod_in;
         lo_part_ff <= lo_part_in;
      end
      if (stage_en.s4) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

[rtl/depth_pixel_backprojection.sv]
// ----------------------------------------------------------------------------
// Depth pixel back-projection
// Lifts one RGB-D pixel through a pinhole model into one colored 3D point.
// ----------------------------------------------------------------------------
// Usage:
// The req channel carries one pixel per transaction (column, row, depth and
// color bytes). A pixel with zero depth is accepted and produces nothing; any
// other pixel produces one transaction on the rsp channel with forward,
// lateral and vertical in Q16.16 and the color bytes unchanged.
// The pipeline has four register stages; one pixel can be accepted in every
// cycle unless a rsp_ready stall has filled all of them.
// The depth multiply, the offset multiply and the split reciprocal multiply
// each take one stage, the sum and saturation take the last one.
// The csr port writes one of the five calibration registers per write. The
// user must write only while no pixel is in flight; block does not enforce it.
// Reset clears all stage valid bits and loads the default calibration.
// When the receiver holds rsp_ready low the last stage holds its result, and
// the earlier stages keep filling until they are all full; only then does
// req_ready drop.
// ----------------------------------------------------------------------------
module depth_pixel_backprojection (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  dpb_pkg::req_type                       req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output dpb_pkg::rsp_type                       rsp_data,
   input  logic                                   csr_write_en,
   input  logic [dpb_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [dpb_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);

   localparam int OW = dpb_pkg::OFFSET_WIDTH;

   logic [23:0] inv_depth_scale_ff;
   logic [15:0] center_col_ff;
   logic [15:0] center_row_ff;
   logic [23:0] inv_focal_x_ff;
   logic [23:0] inv_focal_y_ff;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic ld1, ld2, ld3, ld4;
   dpb_pkg::stage_en_type stage_en;

   logic [39:0]          depth_prod;
   logic [31:0]          fwd1_in, fwd1_ff, fwd2_ff, fwd3_ff, fwd4_ff;
   logic signed [OW-1:0] off_lat_in, off_lat_ff;
   logic signed [OW-1:0] off_ver_in, off_ver_ff;
   logic [23:0]          color1_ff, color2_ff, color3_ff, color4_ff;
   logic signed [31:0]   lateral, vertical;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_depth_scale_ff <= dpb_pkg::INV_DEPTH_SCALE_RESET;
         center_col_ff      <= dpb_pkg::CENTER_COL_RESET;
         center_row_ff      <= dpb_pkg::CENTER_ROW_RESET;
         inv_focal_x_ff     <= dpb_pkg::INV_FOCAL_X_RESET;
         inv_focal_y_ff     <= dpb_pkg::INV_FOCAL_Y_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            dpb_pkg::CSR_INV_DEPTH_SCALE: inv_depth_scale_ff <= csr_wdata;
            dpb_pkg::CSR_CENTER_COL:      center_col_ff      <= csr_wdata[15:0];
            dpb_pkg::CSR_CENTER_ROW:      center_row_ff      <= csr_wdata[15:0];
            dpb_pkg::CSR_INV_FOCAL_X:     inv_focal_x_ff     <= csr_wdata;
            dpb_pkg::CSR_INV_FOCAL_Y:     inv_focal_y_ff     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign ld4 = !v4_ff || rsp_ready;
   assign ld3 = !v3_ff || ld4;
   assign ld2 = !v2_ff || ld3;
   assign ld1 = !v1_ff || ld2;
   assign req_ready = ld1;

   assign stage_en.s2 = ld2;
   assign stage_en.s3 = ld3;
   assign stage_en.s4 = ld4;

   assign depth_prod = {24'd0, req_data.depth} * {16'd0, inv_depth_scale_ff};
   assign fwd1_in    = depth_prod[39:8];
   assign off_lat_in = $signed({2'b00, center_col_ff}) - $signed({2'b00, req_data.col, 4'd0});
   assign off_ver_in = $signed({2'b00, req_data.row, 4'd0}) - $signed({2'b00, center_row_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (ld1) begin
            v1_ff <= req_valid && (req_data.depth != 16'd0);
         end
         if (ld2) begin
            v2_ff <= v1_ff;
         end
         if (ld3) begin
            v3_ff <= v2_ff;
         end
         if (ld4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld1) begin
         fwd1_ff    <= fwd1_in;
         off_lat_ff <= off_lat_in;
         off_ver_ff <= off_ver_in;
         color1_ff  <= {req_data.blue, req_data.green, req_data.red};
      end
      if (ld2) begin
         fwd2_ff   <= fwd1_ff;
         color2_ff <= color1_ff;
      end
      if (ld3) begin
         fwd3_ff   <= fwd2_ff;
         color3_ff <= color2_ff;
      end
      if (ld4) begin
         fwd4_ff   <= fwd3_ff;
         color4_ff <= color3_ff;
      end
   end

   dpb_axis u_lateral (
      .clock     (clock),
      .stage_en  (stage_en),
      .offset    (off_lat_ff),
      .forward   (fwd1_ff),
      .inv_focal (inv_focal_x_ff),
      .result    (lateral)
   );

   dpb_axis u_vertical (
      .clock     (clock),
      .stage_en  (stage_en),
      .offset    (off_ver_ff),
      .forward   (fwd1_ff),
      .inv_focal (inv_focal_y_ff),
      .result    (vertical)
   );

   assign rsp_valid          = v4_ff;
   assign rsp_data.forward   = fwd4_ff;
   assign rsp_data.lateral   = lateral;
   assign rsp_data.vertical  = vertical;
   assign rsp_data.out_blue  = color4_ff[23:16];
   assign rsp_data.out_green = color4_ff[15:8];
   assign rsp_data.out_red   = color4_ff[7:0];

`ifndef SYNTHESIS
   a_zero_depth_dropped: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.depth == 16'd0) |=> !v1_ff)
      else $error("A zero-depth transaction entered the pipeline.");

   a_stalled_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !ld3) |=> (v3_ff && v4_ff))
      else $error("A stalled pipeline stage lost its transaction.");

   a_forward_advances: assert property (@(posedge clock) disable iff (reset)
      (ld4 && v3_ff) |=> (rsp_valid && rsp_data.forward == $past(fwd3_ff)))
      else $error("The forward distance did not advance into the output stage.");
`endif

endmodule

[test/depth_pixel_backprojection_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Depth pixel back-projection testbench
// Drives RGB-D pixels through the block under several calibrations, from the
// reset values to the register extremes, and predicts every colored point in
// fixed point. Each point that leaves the block is compared field by field
// with the oldest predicted point. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module depth_pixel_backprojection_test;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PIPELINE_SETTLE = 8;
   localparam int LONG_HOLD = 300;
   localparam int RANDOM_PHASES = 8;
   localparam int PIXELS_PER_PHASE = 240;
   localparam int CSR_IW = dpb_pkg::CSR_INDEX_WIDTH;
   localparam int CSR_DW = dpb_pkg::CSR_DATA_WIDTH;
   localparam logic signed [95:0] AXIS_MAX = 96'sd2147483647;
   localparam logic signed [95:0] AXIS_MIN = -96'sd2147483648;

   typedef struct packed {
      logic [23:0] inv_depth_scale;
      logic [15:0] center_col;
      logic [15:0] center_row;
      logic [23:0] inv_focal_x;
      logic [23:0] inv_focal_y;
   } calibration_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   dpb_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   dpb_pkg::rsp_type rsp_data;
   logic csr_write_en = 1'b0;
   logic [CSR_IW-1:0] csr_index = '0;
   logic [CSR_DW-1:0] csr_wdata = '0;

   calibration_type cal = '{dpb_pkg::INV_DEPTH_SCALE_RESET, dpb_pkg::CENTER_COL_RESET,
                            dpb_pkg::CENTER_ROW_RESET, dpb_pkg::INV_FOCAL_X_RESET,
                            dpb_pkg::INV_FOCAL_Y_RESET};
   dpb_pkg::rsp_type pending_points[$];
   int failures = 0;
   int cycle_count = 0;
   int burst_left = 0;
   logic hold_request = 1'b0;
   int hold_left = 0;
   int ready_mode = 0;
   int mode_left = 0;

   depth_pixel_backprojection u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic signed [31:0] project_offset(input logic signed [95:0] offset,
                                                         input logic [31:0] fwd,
                                                         input logic [23:0] inv_focal);
      logic signed [95:0] scaled;
      logic signed [95:0] projected;
      scaled = (offset * $signed({64'd0, fwd})) >>> 4;
      projected = (scaled * $signed({72'd0, inv_focal})) >>> 24;
      if (projected > AXIS_MAX) return AXIS_MAX[31:0];
      if (projected < AXIS_MIN) return AXIS_MIN[31:0];
      return projected[31:0];
   endfunction

   function automatic dpb_pkg::rsp_type backproject(input dpb_pkg::req_type px);
      dpb_pkg::rsp_type pt;
      logic [39:0] depth_product;
      logic signed [95:0] col_offset;
      logic signed [95:0] row_offset;
      depth_product = {24'd0, px.depth} * {16'd0, cal.inv_depth_scale};
      pt.forward = depth_product[39:8];
      col_offset = $signed({80'd0, cal.center_col}) - $signed({80'd0, px.col, 4'd0});
      row_offset = $signed({80'd0, px.row, 4'd0}) - $signed({80'd0, cal.center_row});
      pt.lateral = project_offset(col_offset, pt.forward, cal.inv_focal_x);
      pt.vertical = project_offset(row_offset, pt.forward, cal.inv_focal_y);
      pt.out_blue = px.blue;
      pt.out_green = px.green;
      pt.out_red = px.red;
      return pt;
   endfunction

   function automatic dpb_pkg::req_type make_pixel(input logic [11:0] col,
                                                   input logic [11:0] row,
                                                   input logic [15:0] depth,
                                                   input logic [7:0] blue,
                                                   input logic [7:0] green,
                                                   input logic [7:0] red);
      dpb_pkg::req_type px;
      px.col = col;
      px.row = row;
      px.depth = depth;
      px.blue = blue;
      px.green = green;
      px.red = red;
      return px;
   endfunction

   function automatic dpb_pkg::req_type random_pixel();
      dpb_pkg::req_type px;
      int pick;
      pick = $urandom_range(0, 9);
      px.col = (pick == 0) ? 12'd0 : (pick == 1) ? 12'hFFF : 12'($urandom_range(0, 4095));
      pick = $urandom_range(0, 9);
      px.row = (pick == 0) ? 12'd0 : (pick == 1) ? 12'hFFF : 12'($urandom_range(0, 4095));
      pick = $urandom_range(0, 9);
      if (pick == 0) px.depth = 16'd0;
      else if (pick == 1) px.depth = 16'hFFFF;
      else if (pick < 4) px.depth = 16'($urandom_range(1, 255));
      else px.depth = 16'($urandom_range(1, 65535));
      px.blue = 8'($urandom);
      px.green = 8'($urandom);
      px.red = 8'($urandom);
      return px;
   endfunction

   function automatic logic [CSR_DW-1:0] calibration_value(input int lo, input int hi);
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 12) return CSR_DW'($urandom_range(lo, hi));
      if (pick < 15) return '0;
      if (pick < 18) return '1;
      return CSR_DW'($urandom);
   endfunction

   task automatic send_pixel(input dpb_pkg::req_type px);
      req_valid <= 1'b1;
      req_data <= px;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (px.depth != 16'd0) pending_points.insert(pending_points.size(), backproject(px));
   endtask

   task automatic offer_pixel(input dpb_pkg::req_type px);
      send_pixel(px);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(0, 20);
      end
   endtask

   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (PIPELINE_SETTLE) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IW-1:0] index,
                                 input logic [CSR_DW-1:0] value);
      csr_write_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (index)
         dpb_pkg::CSR_INV_DEPTH_SCALE: cal.inv_depth_scale = value;
         dpb_pkg::CSR_CENTER_COL: cal.center_col = value[15:0];
         dpb_pkg::CSR_CENTER_ROW: cal.center_row = value[15:0];
         dpb_pkg::CSR_INV_FOCAL_X: cal.inv_focal_x = value;
         dpb_pkg::CSR_INV_FOCAL_Y: cal.inv_focal_y = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic write_calibration(input logic [23:0] scale, input logic [23:0] ccol,
                                    input logic [23:0] crow, input logic [23:0] fx,
                                    input logic [23:0] fy);
      write_register(dpb_pkg::CSR_INV_DEPTH_SCALE, scale);
      write_register(dpb_pkg::CSR_CENTER_COL, ccol);
      write_register(dpb_pkg::CSR_CENTER_ROW, crow);
      write_register(dpb_pkg::CSR_INV_FOCAL_X, fx);
      write_register(dpb_pkg::CSR_INV_FOCAL_Y, fy);
   endtask

   task automatic compare_field(input string name, input logic [31:0] expected,
                                input logic [31:0] actual);
      if (expected !== actual) begin
         $error("%s mismatch: expected %0h, actual %0h", name, expected, actual);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      dpb_pkg::rsp_type expected;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_points.size() == 0) begin
            $error("Unexpected transaction on rsp: %0h", rsp_data);
            failures++;
         end else begin
            expected = pending_points.pop_front();
            compare_field("forward", expected.forward, rsp_data.forward);
            compare_field("lateral", expected.lateral, rsp_data.lateral);
            compare_field("vertical", expected.vertical, rsp_data.vertical);
            compare_field("out_blue", 32'(expected.out_blue), 32'(rsp_data.out_blue));
            compare_field("out_green", 32'(expected.out_green), 32'(rsp_data.out_green));
            compare_field("out_red", 32'(expected.out_red), 32'(rsp_data.out_red));
         end
      end
   end

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (hold_request) begin
         rsp_ready <= 1'b0;
         hold_left = LONG_HOLD;
         hold_request = 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(50, 600);
         end else begin
            mode_left = mode_left - 1;
         end
         case (ready_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic test_reset_calibration();
      offer_pixel(make_pixel(12'd0, 12'd0, 16'd1, 8'h00, 8'h00, 8'h00));
      offer_pixel(make_pixel(12'hFFF, 12'hFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
      offer_pixel(make_pixel(12'd320, 12'd240, 16'd1000, 8'h12, 8'h34, 8'h56));
      offer_pixel(make_pixel(12'd0, 12'hFFF, 16'd0, 8'hAA, 8'h55, 8'hFF));
      offer_pixel(make_pixel(12'hFFF, 12'd0, 16'd4500, 8'h55, 8'hAA, 8'h00));
      offer_pixel(make_pixel(12'd321, 12'd239, 16'd65000, 8'h80, 8'h01, 8'h7F));
      offer_pixel(make_pixel(12'd100, 12'd400, 16'd0, 8'h0F, 8'hF0, 8'h3C));
      offer_pixel(make_pixel(12'd639, 12'd479, 16'd2, 8'hC3, 8'h5A, 8'hA5));
      wait_until_idle();
   endtask

   task automatic test_register_extremes();
      // Full scale on every register drives both offsets into saturation for the full-depth pixels.
      write_calibration('1, '1, '1, '1, '1);
      offer_pixel(make_pixel(12'd0, 12'd0, 16'hFFFF, 8'h01, 8'h02, 8'h03));
      offer_pixel(make_pixel(12'hFFF, 12'hFFF, 16'hFFFF, 8'hFE, 8'hFD, 8'hFC));
      offer_pixel(make_pixel(12'd0, 12'hFFF, 16'd1, 8'h10, 8'h20, 8'h30));
      offer_pixel(make_pixel(12'hFFF, 12'd0, 16'h8000, 8'h40, 8'h50, 8'h60));
      wait_until_idle();
      write_calibration(24'hFFFFFF, 24'h000000, 24'h000000, 24'hFFFFFF, 24'hFFFFFF);
      offer_pixel(make_pixel(12'hFFF, 12'd0, 16'hFFFF, 8'h11, 8'h22, 8'h33));
      offer_pixel(make_pixel(12'd0, 12'hFFF, 16'hFFFF, 8'h44, 8'h55, 8'h66));
      wait_until_idle();
      write_calibration('0, '0, '0, '0, '0);
      offer_pixel(make_pixel(12'hFFF, 12'hFFF, 16'hFFFF, 8'h77, 8'h88, 8'h99));
      offer_pixel(make_pixel(12'd5, 12'd7, 16'd0, 8'h99, 8'h88, 8'h77));
      wait_until_idle();
      // Bits above the 16-bit center registers must be dropped.
      write_calibration(24'd16777, 24'hAB1400, 24'hCD0F00, 24'd31957, 24'd31957);
      offer_pixel(make_pixel(12'd320, 12'd240, 16'd3000, 8'hDE, 8'hAD, 8'hBE));
      offer_pixel(make_pixel(12'd0, 12'd479, 16'd800, 8'hEF, 8'hBE, 8'hAD));
      wait_until_idle();
      // Writes beyond the register list must leave the calibration alone.
      for (int i = dpb_pkg::CSR_INV_FOCAL_Y + 1; i < 2 ** CSR_IW; i++) begin
         write_register(CSR_IW'(i), '1);
      end
      offer_pixel(make_pixel(12'd17, 12'd455, 16'd12345, 8'h5A, 8'hA5, 8'hC3));
      wait_until_idle();
   endtask

   task automatic test_backpressure();
      write_calibration(24'd16777, 24'd5120, 24'd3840, 24'd31957, 24'd31957);
      hold_request = 1'b1;
      for (int i = 0; i < 60; i++) begin
         send_pixel(random_pixel());
      end
      wait_until_idle();
   endtask

   task automatic test_random_calibrations();
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 0) begin
            write_calibration(dpb_pkg::INV_DEPTH_SCALE_RESET, dpb_pkg::CENTER_COL_RESET,
                              dpb_pkg::CENTER_ROW_RESET, dpb_pkg::INV_FOCAL_X_RESET,
                              dpb_pkg::INV_FOCAL_Y_RESET);
         end else begin
            write_calibration(calibration_value(100, 70000), calibration_value(0, 65535),
                              calibration_value(0, 65535), calibration_value(2000, 200000),
                              calibration_value(2000, 200000));
         end
         for (int i = 0; i < PIXELS_PER_PHASE; i++) begin
            offer_pixel(random_pixel());
         end
         wait_until_idle();
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_calibration();
      test_register_extremes();
      test_backpressure();
      test_random_calibrations();
      wait_until_idle();
      repeat (20) @(posedge clock);
      if (failures == 0 && pending_points.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
